// File: hw/rtl/tmprof_pkg.sv
package tmprof_pkg;

  localparam int Q_FRAC     = 16;
  localparam int CFG_W      = 31;
  localparam int CFG_IDX_W  = 1;
  localparam int VAL_W      = 32;
  localparam int PROD_W     = 2 * VAL_W;
  localparam int QUO_W      = 48;
  localparam int DIV_STEPS  = 48;
  localparam int SQRT_STEPS = 32;
  localparam int STEP_W     = 6;

  localparam logic [CFG_W-1:0] MAX31     = 31'h7FFF_FFFF;
  localparam logic [VAL_W-1:0] MAX32     = 32'hFFFF_FFFF;
  localparam logic [CFG_W-1:0] CFG_RESET = 31'h0001_0000;
  localparam logic [QUO_W-1:0] Q_NO_ACCEL = 48'h8000_0000_0000;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_VELOCITY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_TIME    = 1'b1;

  typedef enum logic {
    DS_DIV,
    DS_SQRT
  } ds_op_t;

  typedef struct packed {
    logic   start;
    ds_op_t op;
  } ds_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ds_stat_t;

endpackage

// File: hw/rtl/tmprof_ifs.sv
interface tmprof_item_if;
  import tmprof_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    kind;
  logic signed [VAL_W-1:0] goal_distance;
  logic signed [VAL_W-1:0] current_position;
  logic [VAL_W-1:0]        time_now;

  modport source (
    output valid, kind, goal_distance, current_position, time_now,
    input  ready
  );

  modport sink (
    input  valid, kind, goal_distance, current_position, time_now,
    output ready
  );
endinterface

interface tmprof_result_if;
  import tmprof_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] ref_displacement;
  logic [CFG_W-1:0]        ref_velocity;
  logic signed [VAL_W-1:0] ref_acceleration;

  modport source (
    output valid, ref_displacement, ref_velocity, ref_acceleration,
    input  ready
  );

  modport sink (
    input  valid, ref_displacement, ref_velocity, ref_acceleration,
    output ready
  );
endinterface

// File: hw/rtl/tmprof_mul.sv
module tmprof_mul (
  input  logic                          clk,
  input  logic                          en,
  input  logic [tmprof_pkg::VAL_W-1:0]  a,
  input  logic [tmprof_pkg::VAL_W-1:0]  b,
  output logic [tmprof_pkg::PROD_W-1:0] prod
);
  import tmprof_pkg::*;

  logic [PROD_W-1:0] full;

  assign full = {{(PROD_W-VAL_W){1'b0}}, a} * {{(PROD_W-VAL_W){1'b0}}, b};

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= full;
    end
  end

endmodule

// File: hw/rtl/tmprof_divsqrt.sv
module tmprof_divsqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  tmprof_pkg::ds_ctrl_t          ctrl,
  input  logic [tmprof_pkg::PROD_W-1:0] operand,
  input  logic [tmprof_pkg::CFG_W-1:0]  divisor,
  output logic [tmprof_pkg::QUO_W-1:0]  res,
  output tmprof_pkg::ds_stat_t          stat
);
  import tmprof_pkg::*;

  logic [PROD_W-1:0] work;
  logic [34:0]       rem;
  logic [CFG_W-1:0]  dvs;
  ds_op_t            op;
  logic [STEP_W-1:0] count;
  logic [STEP_W-1:0] last;
  logic              busy;
  logic              done;
  logic [34:0]       part;
  logic [34:0]       trial;
  logic [35:0]       diff;
  logic              fits;

  always_comb begin
    if (op == DS_SQRT) begin
      last  = STEP_W'(SQRT_STEPS - 1);
      part  = {rem[32:0], work[PROD_W-1 -: 2]};
      trial = {1'b0, res[31:0], 2'b01};
    end else begin
      last  = STEP_W'(DIV_STEPS - 1);
      part  = {rem[33:0], work[PROD_W-1]};
      trial = {4'b0000, dvs};
    end
    diff = {1'b0, part} - {1'b0, trial};
    fits = !diff[35];
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      rem <= '0;
      res <= '0;
      dvs <= divisor;
      if (ctrl.op == DS_SQRT) begin
        work <= operand;
      end else begin
        work <= {operand[QUO_W-1:0], {(PROD_W-QUO_W){1'b0}}};
      end
    end else if (busy) begin
      rem <= fits ? diff[34:0] : part;
      res <= {res[QUO_W-2:0], fits};
      if (op == DS_SQRT) begin
        work <= {work[PROD_W-3:0], 2'b00};
      end else begin
        work <= {work[PROD_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
      op    <= DS_DIV;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy  <= 1'b1;
        count <= '0;
        op    <= ctrl.op;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

  a_no_restart: assert property (@(posedge clk) disable iff (rst) ctrl.start |-> !busy)
    else $error("divsqrt started while busy");
  a_done_on_fall: assert property (@(posedge clk) disable iff (rst) $fell(busy) |-> done)
    else $error("divsqrt finished without done");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divsqrt done while busy");

endmodule

// File: hw/rtl/trapezoid_motion_profile_unit.sv
// Channel  Dir  Transfer when        Carries
// item     in   valid & ready        kind, goal_distance, current_position, time_now
// result   out  valid & ready        ref_displacement, ref_velocity, ref_acceleration
// cfg      in   cfg_we               cfg_index, cfg_data (max_velocity, ramp_time)
//
// Tick: REGION, VEL_MUL, VEL, STEP_MUL, SUM; one 32x32 multiplier used twice.
// Start: no result; a trapezoid runs the 48-step divider twice, a triangle runs it
//   twice and then the 32-step square root, a triangle with zero acceleration runs
//   it once and then the root, all on the same shared unit.
// item.ready is high only between items; a full result register holds a tick back.
// Reset (rst, sync) clears state, times, peak, accel, position; both registers get 1.0.
module trapezoid_motion_profile_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [tmprof_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tmprof_pkg::CFG_W-1:0]     cfg_data,
  tmprof_item_if.sink                      item,
  tmprof_result_if.source                  result
);
  import tmprof_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACCEL,
    ST_ACCEL_WAIT,
    ST_BRANCH,
    ST_Q_WAIT,
    ST_SQRT,
    ST_SQRT_WAIT,
    ST_PEAK_MUL,
    ST_PEAK,
    ST_CRUISE_WAIT,
    ST_TOTAL,
    ST_REGION,
    ST_VEL_MUL,
    ST_VEL,
    ST_STEP_MUL,
    ST_SUM
  } state_t;

  typedef enum logic [1:0] {
    RG_UP,
    RG_CRUISE,
    RG_DOWN,
    RG_STOP
  } region_t;

  state_t                  state;
  region_t                 region;
  logic [CFG_W-1:0]        max_velocity;
  logic [CFG_W-1:0]        ramp_time;
  logic                    direction_negative;
  logic [CFG_W-1:0]        accel_value;
  logic [VAL_W-1:0]        ramp_end_time;
  logic [VAL_W-1:0]        cruise_end_time;
  logic [VAL_W-1:0]        total_time;
  logic [CFG_W-1:0]        peak_velocity;
  logic signed [VAL_W-1:0] displacement;
  logic [VAL_W-1:0]        previous_time;
  logic [VAL_W-1:0]        tick_time;
  logic [VAL_W-1:0]        move_dist;
  logic                    triangular;
  logic [QUO_W-1:0]        q_val;
  logic [VAL_W-1:0]        op_b;
  logic [CFG_W-1:0]        vel;
  logic signed [VAL_W-1:0] acc;
  logic [VAL_W-1:0]        dt;
  logic                    back;

  logic                    out_valid;
  logic signed [VAL_W-1:0] out_disp;
  logic [CFG_W-1:0]        out_vel;
  logic signed [VAL_W-1:0] out_acc;

  logic                    accept;
  logic                    slot_free;
  logic [VAL_W:0]          pos_diff;
  logic                    neg_in;
  logic [VAL_W-1:0]        goal_neg;
  logic [VAL_W-1:0]        dist_in;

  logic                    mul_en;
  logic [VAL_W-1:0]        mul_a;
  logic [VAL_W-1:0]        mul_b;
  logic [PROD_W-1:0]       mul_prod;

  ds_ctrl_t                ds_ctrl;
  ds_stat_t                ds_stat;
  logic [PROD_W-1:0]       ds_operand;
  logic [CFG_W-1:0]        ds_divisor;
  logic [QUO_W-1:0]        ds_res;

  logic [CFG_W-1:0]        accel_sat;
  logic [VAL_W-1:0]        cruise_sat;
  logic                    tri_cond;
  logic [VAL_W-1:0]        root;
  logic [VAL_W-1:0]        total_tri;
  logic [VAL_W:0]          total_sum;
  logic [VAL_W-1:0]        total_trap;
  logic [CFG_W-1:0]        prod_sat;
  logic [46:0]             prod_hi;
  logic [CFG_W-1:0]        down_vel;
  logic                    t_lt_ramp;
  logic                    t_lt_cruise;
  logic                    t_lt_total;
  logic                    step_neg;
  logic [48:0]             sum_wide;
  logic signed [VAL_W-1:0] sum_sat;

  tmprof_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (mul_prod)
  );

  tmprof_divsqrt u_divsqrt (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ds_ctrl),
    .operand (ds_operand),
    .divisor (ds_divisor),
    .res     (ds_res),
    .stat    (ds_stat)
  );

  assign item.ready = (state == ST_IDLE);
  assign accept     = item.valid && item.ready;
  assign slot_free  = !out_valid || result.ready;

  assign result.valid            = out_valid;
  assign result.ref_displacement = out_disp;
  assign result.ref_velocity     = out_vel;
  assign result.ref_acceleration = out_acc;

  // direction and distance of a new move
  assign pos_diff = {item.goal_distance[VAL_W-1], item.goal_distance}
                  - {item.current_position[VAL_W-1], item.current_position};
  assign neg_in   = pos_diff[VAL_W];
  assign goal_neg = ~item.goal_distance + 1'b1;

  always_comb begin
    if (neg_in) begin
      dist_in = item.goal_distance[VAL_W-1] ? goal_neg : '0;
    end else begin
      dist_in = item.goal_distance[VAL_W-1] ? '0 : item.goal_distance;
    end
  end

  assign accel_sat  = (|ds_res[QUO_W-1:CFG_W]) ? MAX31 : ds_res[CFG_W-1:0];
  assign cruise_sat = (|ds_res[QUO_W-1:VAL_W]) ? MAX32 : ds_res[VAL_W-1:0];
  assign tri_cond   = mul_prod > {{(PROD_W-VAL_W-Q_FRAC){1'b0}}, move_dist, {Q_FRAC{1'b0}}};
  assign root       = ds_res[VAL_W-1:0];
  assign total_tri  = root[VAL_W-1] ? MAX32 : {root[VAL_W-2:0], 1'b0};
  assign total_sum  = {1'b0, cruise_end_time} + {2'b00, ramp_time};
  assign total_trap = total_sum[VAL_W] ? MAX32 : total_sum[VAL_W-1:0];
  assign prod_hi    = mul_prod[PROD_W-2:Q_FRAC];
  assign prod_sat   = (|mul_prod[PROD_W-1:Q_FRAC+CFG_W]) ? MAX31 : mul_prod[Q_FRAC+CFG_W-1:Q_FRAC];
  assign down_vel   = (prod_hi >= {16'b0, peak_velocity}) ? '0
                    : peak_velocity - prod_hi[CFG_W-1:0];

  assign t_lt_ramp   = tick_time < ramp_end_time;
  assign t_lt_cruise = tick_time < cruise_end_time;
  assign t_lt_total  = tick_time < total_time;

  assign step_neg = direction_negative ^ back;
  assign sum_wide = step_neg
                  ? {{17{displacement[VAL_W-1]}}, displacement} - {2'b00, prod_hi}
                  : {{17{displacement[VAL_W-1]}}, displacement} + {2'b00, prod_hi};

  always_comb begin
    if ((&sum_wide[48:VAL_W-1]) || !(|sum_wide[48:VAL_W-1])) begin
      sum_sat = sum_wide[VAL_W-1:0];
    end else if (sum_wide[48]) begin
      sum_sat = 32'sh8000_0000;
    end else begin
      sum_sat = 32'sh7FFF_FFFF;
    end
  end

  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    case (state)
      ST_ACCEL: begin
        mul_en = 1'b1;
        mul_a  = {1'b0, max_velocity};
        mul_b  = {1'b0, ramp_time};
      end
      ST_PEAK_MUL: begin
        mul_en = 1'b1;
        mul_a  = {1'b0, accel_value};
        mul_b  = ramp_end_time;
      end
      ST_VEL_MUL: begin
        mul_en = 1'b1;
        mul_a  = {1'b0, accel_value};
        mul_b  = op_b;
      end
      ST_STEP_MUL: begin
        mul_en = 1'b1;
        mul_a  = {1'b0, vel};
        mul_b  = dt;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    ds_ctrl.start = 1'b0;
    ds_ctrl.op    = DS_DIV;
    ds_operand    = '0;
    ds_divisor    = '0;
    case (state)
      ST_ACCEL: begin
        ds_ctrl.start = 1'b1;
        ds_operand    = {{(PROD_W-CFG_W-Q_FRAC){1'b0}}, max_velocity, {Q_FRAC{1'b0}}};
        ds_divisor    = ramp_time;
      end
      ST_BRANCH: begin
        ds_ctrl.start = !(triangular && (accel_value == '0));
        ds_operand    = {{(PROD_W-VAL_W-Q_FRAC){1'b0}}, move_dist, {Q_FRAC{1'b0}}};
        ds_divisor    = triangular ? accel_value : max_velocity;
      end
      ST_SQRT: begin
        ds_ctrl.start = 1'b1;
        ds_ctrl.op    = DS_SQRT;
        ds_operand    = {q_val, {Q_FRAC{1'b0}}};
      end
      default: begin
        ds_ctrl.start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_velocity <= CFG_RESET;
      ramp_time    <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_VELOCITY: max_velocity <= cfg_data;
        CFG_RAMP_TIME:    ramp_time    <= cfg_data;
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      out_valid          <= 1'b0;
      direction_negative <= 1'b0;
      accel_value        <= '0;
      ramp_end_time      <= '0;
      cruise_end_time    <= '0;
      total_time         <= '0;
      peak_velocity      <= '0;
      displacement       <= '0;
      previous_time      <= '0;
    end else begin
      if (result.ready && state != ST_SUM) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (item.kind == KIND_START) begin
              direction_negative <= neg_in;
              move_dist          <= dist_in;
              displacement       <= '0;
              previous_time      <= '0;
              state              <= ST_ACCEL;
            end else begin
              tick_time <= item.time_now;
              state     <= ST_REGION;
            end
          end
        end
        ST_ACCEL: begin
          state <= ST_ACCEL_WAIT;
        end
        ST_ACCEL_WAIT: begin
          if (ds_stat.done) begin
            accel_value <= accel_sat;
            triangular  <= tri_cond;
            state       <= ST_BRANCH;
          end
        end
        ST_BRANCH: begin
          if (triangular) begin
            if (accel_value == '0) begin
              q_val <= Q_NO_ACCEL;
              state <= ST_SQRT;
            end else begin
              state <= ST_Q_WAIT;
            end
          end else begin
            ramp_end_time <= {1'b0, ramp_time};
            peak_velocity <= max_velocity;
            state         <= ST_CRUISE_WAIT;
          end
        end
        ST_Q_WAIT: begin
          if (ds_stat.done) begin
            q_val <= ds_res;
            state <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          state <= ST_SQRT_WAIT;
        end
        ST_SQRT_WAIT: begin
          if (ds_stat.done) begin
            ramp_end_time   <= root;
            cruise_end_time <= root;
            total_time      <= total_tri;
            state           <= ST_PEAK_MUL;
          end
        end
        ST_PEAK_MUL: begin
          state <= ST_PEAK;
        end
        ST_PEAK: begin
          peak_velocity <= prod_sat;
          state         <= ST_IDLE;
        end
        ST_CRUISE_WAIT: begin
          if (ds_stat.done) begin
            cruise_end_time <= cruise_sat;
            state           <= ST_TOTAL;
          end
        end
        ST_TOTAL: begin
          total_time <= total_trap;
          state      <= ST_IDLE;
        end
        ST_REGION: begin
          if (t_lt_ramp) begin
            region <= RG_UP;
            op_b   <= tick_time;
          end else if (t_lt_cruise) begin
            region <= RG_CRUISE;
            op_b   <= tick_time;
          end else if (t_lt_total) begin
            region <= RG_DOWN;
            op_b   <= tick_time - cruise_end_time;
          end else begin
            region <= RG_STOP;
            op_b   <= tick_time;
          end
          state <= ST_VEL_MUL;
        end
        ST_VEL_MUL: begin
          state <= ST_VEL;
        end
        ST_VEL: begin
          case (region)
            RG_UP: begin
              vel <= prod_sat;
              acc <= {1'b0, accel_value};
            end
            RG_CRUISE: begin
              vel <= peak_velocity;
              acc <= '0;
            end
            RG_DOWN: begin
              vel <= down_vel;
              acc <= -signed'({1'b0, accel_value});
            end
            default: begin
              vel <= '0;
              acc <= '0;
            end
          endcase
          back <= tick_time < previous_time;
          dt   <= (tick_time < previous_time) ? previous_time - tick_time
                                               : tick_time - previous_time;
          state <= ST_STEP_MUL;
        end
        ST_STEP_MUL: begin
          state <= ST_SUM;
        end
        ST_SUM: begin
          if (slot_free) begin
            displacement  <= sum_sat;
            previous_time <= tick_time;
            out_disp      <= sum_sat;
            out_vel       <= vel;
            out_acc       <= acc;
            out_valid     <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_start_no_result: assert property (@(posedge clk) disable iff (rst)
      (accept && item.kind == KIND_START) |=> !$rose(out_valid))
    else $error("result produced for a start transfer");
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
      accept |=> !item.ready)
    else $error("item taken again straight after a transfer");
  a_accel_values: assert property (@(posedge clk) disable iff (rst)
      $rose(out_valid) |-> (out_acc == '0 || out_acc == signed'({1'b0, accel_value})
                            || out_acc == -signed'({1'b0, accel_value})))
    else $error("acceleration outside the profile values");

endmodule
